/* hw/rtl/lzhc_pkg.sv */
// Package with shared constants, types and the bucket hash for the hash chain match finder.
`timescale 1ns / 1ps
package lzhc_pkg;
  localparam int NUM_BUCKETS = 251;
  localparam int MAX_CHAIN = 16;
  localparam int WINDOW_DEPTH = 32768;
  localparam int BKT_W = 8;
  localparam logic [0:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [0:0] CFG_CHAIN_LIMIT = 1'd1;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic add_chain;
    logic add_win;
    logic walk_start;
    logic chain_rd;
    logic cand_eval;
    logic win_rd;
    logic win_cmp;
    logic res_load;
  } lzhc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_find;
    logic short_win;
    logic walk_end;
    logic cand_skip;
    logic cand_stop;
    logic byte_ok;
    logic last_byte;
  } lzhc_sts_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c);
    logic [14:0] s;
    logic [14:0] q;
    s = {1'b0, a, 6'd0} + {4'd0, b, 3'd0} + {7'd0, c};
    q = s;
    if (q >= 15'd16064) q = q - 15'd16064;
    if (q >= 15'd8032) q = q - 15'd8032;
    if (q >= 15'd4016) q = q - 15'd4016;
    if (q >= 15'd2008) q = q - 15'd2008;
    if (q >= 15'd1004) q = q - 15'd1004;
    if (q >= 15'd502) q = q - 15'd502;
    if (q >= 15'd251) q = q - 15'd251;
    return q[BKT_W-1:0];
  endfunction
endpackage

/* hw/rtl/lzhc_ctrl.sv */
// Controller state machine sequencing adds, finds and the chain clearing pass.
`timescale 1ns / 1ps
module lzhc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lzhc_pkg::lzhc_cmd_t cmd,
  input  lzhc_pkg::lzhc_sts_t sts
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD, S_START, S_CRD, S_CEVAL, S_WRD, S_WCMP, S_RES, S_OUT
  } state_t;
  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_nxt = sts.is_find ? S_START : S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        cmd.add_win = 1'b1;
        state_nxt = S_IDLE;
      end
      S_START: begin
        cmd.walk_start = 1'b1;
        state_nxt = sts.short_win ? S_RES : S_CRD;
      end
      S_CRD: begin
        cmd.chain_rd = 1'b1;
        state_nxt = S_CEVAL;
      end
      S_CEVAL: begin
        cmd.cand_eval = 1'b1;
        priority if (sts.cand_stop) state_nxt = S_RES;
        else if (sts.cand_skip) state_nxt = sts.walk_end ? S_RES : S_CRD;
        else state_nxt = S_WRD;
      end
      S_WRD: begin
        cmd.win_rd = 1'b1;
        state_nxt = S_WCMP;
      end
      S_WCMP: begin
        cmd.win_cmp = 1'b1;
        priority if (!sts.byte_ok) state_nxt = sts.walk_end ? S_RES : S_CRD;
        else if (sts.last_byte) state_nxt = S_RES;
        else state_nxt = S_WRD;
      end
      S_RES: begin
        cmd.res_load = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("Result item dropped while stalled.");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("Item accepted while busy.");
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("Result during clearing pass.");
endmodule

/* hw/rtl/lzhc_datapath.sv */
// Datapath with history, chain and window memories, the walk registers and the result.
`timescale 1ns / 1ps
module lzhc_datapath #(
  parameter int MAX_CHAIN = lzhc_pkg::MAX_CHAIN,
  parameter int WINDOW_DEPTH = lzhc_pkg::WINDOW_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_action,
  input  logic [7:0]          in_data_byte,
  input  logic [7:0]          in_query_first,
  input  logic [7:0]          in_query_second,
  input  logic [7:0]          in_query_third,
  input  logic [15:0]         in_min_distance,
  output logic                out_found,
  output logic [15:0]         out_match_distance,
  input  lzhc_pkg::lzhc_cmd_t cmd,
  output lzhc_pkg::lzhc_sts_t sts
);
  localparam int SW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int LW = $clog2(MAX_CHAIN + 1);
  localparam int WW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1) > 16 ? $clog2(WINDOW_DEPTH + 1) : 16;
  localparam int BW = lzhc_pkg::BKT_W;
  localparam int NB = lzhc_pkg::NUM_BUCKETS;
  localparam int CD = NB * MAX_CHAIN;
  localparam int CAW = $clog2(CD);

  logic [31:0] chain_mem [CD];
  logic [7:0]  win_mem [WINDOW_DEPTH];
  logic [SW-1:0] heads_mem [NB];

  logic [15:0] wsize_r;
  logic [4:0]  climit_r;
  logic [7:0]  rb_r [3];
  logic [31:0] cnt_r;
  logic [FW-1:0] fill_r;
  logic [WW-1:0] widx_r;
  logic [CAW-1:0] clr_r;
  logic [7:0]  q_r [3];
  logic [15:0] mind_r;
  logic [7:0]  addb_r;
  logic        act_r;
  logic [BW-1:0] h_r;
  logic [SW-1:0] head_r;
  logic [SW-1:0] ci_r;
  logic [SW-1:0] ci_dec;
  logic [LW-1:0] steps_r;
  logic [LW-1:0] lim;
  logic [FW-1:0] ew, held;
  logic [31:0] cand_r, dist_r;
  logic [31:0] dcand;
  logic [1:0]  k_r;
  logic [7:0]  wbyte_r;
  logic        hit_r;
  logic [15:0] res_r;
  logic        found_r;
  logic [SW-1:0] aslot;
  logic [SW-1:0] hnext;
  logic [BW-1:0] ah, qh, hsel;
  logic [31:0] dk;

  always_comb begin
    if (climit_r == 5'd0) lim = LW'(1);
    else if ({27'd0, climit_r} > 32'(MAX_CHAIN)) lim = LW'(MAX_CHAIN);
    else lim = LW'(climit_r);
    if (32'(wsize_r) > 32'(WINDOW_DEPTH)) ew = FW'(WINDOW_DEPTH);
    else ew = FW'(wsize_r);
    held = (fill_r < ew) ? fill_r : ew;
    ah = lzhc_pkg::bucket_of(rb_r[1], rb_r[2], in_data_byte);
    qh = lzhc_pkg::bucket_of(in_query_first, in_query_second, in_query_third);
    hsel = in_action ? qh : ah;
    aslot = (LW'(head_r) >= lim) ? '0 : head_r;
    hnext = (LW'(aslot) + LW'(1) >= lim) ? '0 : aslot + SW'(1);
    ci_dec = (ci_r == '0) ? SW'(lim - LW'(1)) : ci_r - SW'(1);
    dcand = cnt_r - cand_r - 32'd1;
    dk = dist_r + {30'd0, 2'd2 - k_r};
  end

  assign sts.clr_done = (32'(clr_r) == CD - 1);
  assign sts.is_find = in_action;
  assign sts.short_win = (held < FW'(3));
  assign sts.walk_end = (steps_r == lim);
  assign sts.cand_skip = (dcand < {16'd0, mind_r});
  assign sts.cand_stop = !sts.cand_skip && (dcand >= 32'(held) - 32'd2);
  assign sts.byte_ok = (wbyte_r == q_r[k_r]);
  assign sts.last_byte = (k_r == 2'd2);

  always_ff @(posedge clk) begin
    if (cmd.clr_step) chain_mem[clr_r] <= '0;
    else if (cmd.add_chain) chain_mem[CAW'(32'(h_r) * MAX_CHAIN + 32'(aslot))] <= cnt_r;
    if (cmd.chain_rd) cand_r <= chain_mem[CAW'(32'(h_r) * MAX_CHAIN + 32'(ci_dec))];
    if (cmd.clr_step && (32'(clr_r) < NB)) heads_mem[BW'(clr_r)] <= '0;
    else if (cmd.add_chain) heads_mem[h_r] <= hnext;
    if (cmd.load) head_r <= heads_mem[hsel];
    if (cmd.add_win) win_mem[widx_r] <= addb_r;
    if (cmd.win_rd) wbyte_r <= win_mem[WW'(widx_r - WW'(dk) - WW'(1))];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      addb_r <= in_data_byte;
      q_r[0] <= in_query_first;
      q_r[1] <= in_query_second;
      q_r[2] <= in_query_third;
      mind_r <= in_min_distance;
      h_r <= hsel;
    end
    if (cmd.walk_start) begin
      hit_r <= 1'b0;
      steps_r <= '0;
      ci_r <= (LW'(head_r) > lim) ? SW'(lim) : head_r;
    end
    if (cmd.chain_rd) begin
      ci_r <= ci_dec;
      steps_r <= steps_r + LW'(1);
    end
    if (cmd.cand_eval) begin
      dist_r <= dcand;
      k_r <= 2'd0;
    end
    if (cmd.win_cmp) begin
      k_r <= k_r + 2'd1;
      if (sts.byte_ok && sts.last_byte) begin
        hit_r <= 1'b1;
        res_r <= dist_r[15:0] + 16'd2;
      end
    end
    if (cmd.res_load) begin
      found_r <= hit_r && act_r && !sts.short_win;
      out_match_distance <= (hit_r && !sts.short_win) ? res_r : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= 16'd32768;
      climit_r <= 5'd16;
      rb_r[0] <= '0; rb_r[1] <= '0; rb_r[2] <= '0;
      cnt_r <= '0;
      fill_r <= '0;
      widx_r <= '0;
      clr_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lzhc_pkg::CFG_WINDOW_SIZE) wsize_r <= cfg_data;
        else climit_r <= cfg_data[4:0];
      end
      if (cmd.clr_step) clr_r <= clr_r + CAW'(1);
      if (cmd.load && !in_action) begin
        rb_r[0] <= rb_r[1];
        rb_r[1] <= rb_r[2];
        rb_r[2] <= in_data_byte;
      end
      if (cmd.add_chain) begin
        cnt_r <= cnt_r + 32'd1;
        widx_r <= widx_r + WW'(1);
        if (fill_r < ew) fill_r <= fill_r + FW'(1);
        else fill_r <= ew;
      end
    end
  end

  assign out_found = found_r;
endmodule

/* hw/rtl/lz_hash_chain_match_finder.sv */
// Top level of the hash chain match finder.
// After reset the block clears its chain store and bucket heads (one slot a cycle) and
// accepts no item meanwhile. An add loads the item, then writes the chain store, bucket head
// and window. A find walks at most chain_limit candidates; for each it reads the chain
// slot, checks the distance, then compares window bytes one at a time. Configuration writes
// are always accepted and are to be issued only while no item is in flight.
`timescale 1ns / 1ps
module lz_hash_chain_match_finder #(
  parameter int MAX_CHAIN = lzhc_pkg::MAX_CHAIN,
  parameter int WINDOW_DEPTH = lzhc_pkg::WINDOW_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_query_first,
  input  logic [7:0]  in_query_second,
  input  logic [7:0]  in_query_third,
  input  logic [15:0] in_min_distance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [15:0] out_match_distance
);
  lzhc_pkg::lzhc_cmd_t cmd;
  lzhc_pkg::lzhc_sts_t sts;
  logic out_v;

  assign cfg_ready = 1'b1;

  lzhc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_v), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  lzhc_datapath #(.MAX_CHAIN(MAX_CHAIN), .WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_action(in_action), .in_data_byte(in_data_byte),
    .in_query_first(in_query_first), .in_query_second(in_query_second),
    .in_query_third(in_query_third), .in_min_distance(in_min_distance),
    .out_found(out_found), .out_match_distance(out_match_distance),
    .cmd(cmd), .sts(sts)
  );

  assign out_valid = out_v;
endmodule
